[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[sv/crc8s_pkg.sv]
// ----------------------------------------------------------------------------
// crc8s_pkg
// shared types and constants of the reply frame scanner
// ----------------------------------------------------------------------------
package crc8s_pkg;

	localparam int FRAME_BYTES = 8;

	localparam logic [3:0] FRAME_LEN    = 4'd8;
	localparam logic [3:0] MAX_RX_BYTES = 4'd12;

	localparam logic [7:0] SYNC_BYTE  = 8'h05;
	localparam logic [7:0] REPLY_ADDR = 8'hFF;
	localparam logic [6:0] REG_MASK   = 7'h7F;
	localparam logic [7:0] CRC_POLY   = 8'h07;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SHORT    = 2'd1;
	localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

	// entry 0 is the oldest byte
	typedef logic [0:FRAME_BYTES-1][7:0] window_t;

	typedef struct packed {
		logic        match;
		logic [7:0]  reg_byte;
		logic [31:0] data;
	} frame_info_t;

endpackage

[sv/crc8s_frame_check.sv]
// ----------------------------------------------------------------------------
// crc8s_frame_check
// checks one 8-byte window as a reply frame: sync, address, register, crc8
// ----------------------------------------------------------------------------
module crc8s_frame_check (
	input  crc8s_pkg::window_t     window,
	input  logic [6:0]             want_reg,
	output crc8s_pkg::frame_info_t info
);
	import crc8s_pkg::*;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
		input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = crc_in;
		for (int k = 0; k < 8; k++) begin
			fb = c[7] ^ data[k];
			c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	logic [7:0] crc;

	always_comb begin
		crc = 8'h00;
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			crc = crc8_byte(crc, window[i]);
		end
	end

	always_comb begin
		info.match    = (window[0] == SYNC_BYTE) && (window[1] == REPLY_ADDR)
			&& ((window[2][6:0] & REG_MASK) == want_reg)
			&& (crc == window[FRAME_BYTES-1]);
		info.reg_byte = window[2];
		info.data     = {window[3], window[4], window[5], window[6]};
	end

endmodule

[sv/crc8_reply_frame_scanner_top.sv]
// result: registered into the output registers when the item carrying burst_end leaves the input register
// throughput: one byte per cycle if not stalled; input reg, one combinational pass
// a held result stalls a burst-end item in the input register and the input behind it
// reset: arst_n clears the byte count, found flag and both valid flags at once
// ----------------------------------------------------------------------------
// crc8_reply_frame_scanner_top
// sliding-window uart reply deframer with crc8 check and burst-end report
// ----------------------------------------------------------------------------
module crc8_reply_frame_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        burst_end,
	input  logic [6:0]  expected_reg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  reply_reg,
	output logic [31:0] reply_data,
	output logic [3:0]  byte_count
);
	import crc8s_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic [6:0] want_s1;

	window_t     window_q;
	logic [3:0]  seen_q;
	logic        found_q;
	logic [7:0]  held_reg_q;
	logic [31:0] held_data_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  reply_reg_q;
	logic [31:0] reply_data_q;
	logic [3:0]  byte_count_q;

	logic        out_free;
	logic        consume;
	logic        room;
	window_t     next_window;
	logic [3:0]  seen_next;
	frame_info_t info;
	logic        hit;
	logic        found_next;
	logic [7:0]  reg_next;
	logic [31:0] data_next;

	assign out_free    = !out_valid_q || !out_stall;
	assign consume     = valid_s1 && (!last_s1 || out_free);
	assign in_stall    = valid_s1 && !consume;
	assign room        = seen_q < MAX_RX_BYTES;
	assign next_window = {window_q[1:FRAME_BYTES-1], byte_s1};
	assign seen_next   = room ? seen_q + 4'd1 : seen_q;

	crc8s_frame_check u_check (
		.window   (next_window),
		.want_reg (want_s1),
		.info     (info)
	);

	assign hit        = room && (seen_next >= FRAME_LEN) && info.match;
	assign found_next = found_q || hit;
	assign reg_next   = hit ? info.reg_byte : held_reg_q;
	assign data_next  = hit ? info.data : held_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			last_s1 <= burst_end;
			want_s1 <= expected_reg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 4'd0;
			found_q <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				seen_q  <= 4'd0;
				found_q <= 1'b0;
			end else begin
				seen_q  <= seen_next;
				found_q <= found_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && !last_s1) begin
			if (room) begin
				window_q <= next_window;
			end
			held_reg_q  <= reg_next;
			held_data_q <= data_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			byte_count_q <= seen_next;
			if (seen_next < FRAME_LEN) begin
				status_q     <= STATUS_SHORT;
				reply_reg_q  <= 8'h00;
				reply_data_q <= 32'h0;
			end else if (found_next) begin
				status_q     <= STATUS_OK;
				reply_reg_q  <= reg_next;
				reply_data_q <= data_next;
			end else begin
				status_q     <= STATUS_NO_FRAME;
				reply_reg_q  <= 8'h00;
				reply_data_q <= 32'h0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign reply_reg  = reply_reg_q;
	assign reply_data = reply_data_q;
	assign byte_count = byte_count_q;

endmodule

[sv/crc8s_checker.sv]
// ----------------------------------------------------------------------------
// crc8s_checker
// port-level checks on the result channel of the reply frame scanner
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8s_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [7:0]  reply_reg,
	input logic [31:0] reply_data,
	input logic [3:0]  byte_count
);
	import crc8s_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(reply_reg) && $stable(reply_data) && $stable(byte_count))
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, out_valid, status == STATUS_OK || status == STATUS_SHORT || status == STATUS_NO_FRAME)
	`ASSERT_IMPLIES(a_miss_zero, clk, arst_n, out_valid && status != STATUS_OK, reply_reg == 8'h00 && reply_data == 32'h0)
	`ASSERT_IMPLIES(a_short_count, clk, arst_n, out_valid, (status == STATUS_SHORT) == (byte_count < FRAME_LEN))
	`ASSERT_IMPLIES(a_count_max, clk, arst_n, out_valid, byte_count <= MAX_RX_BYTES)

endmodule

bind crc8_reply_frame_scanner_top crc8s_checker u_crc8s_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.reply_reg  (reply_reg),
	.reply_data (reply_data),
	.byte_count (byte_count)
);
